// ===== sv/rbs_pkg.sv =====
// Package for the ray/box slab test: widths, item types and lane result type.
// Used by the interfaces and by every module of the block.
package rbs_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_AXES    = 3;
    localparam int NUM_LANES   = 2 * NUM_AXES;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int NUM_WIDTH   = DIFF_WIDTH + FRAC_BITS;
    localparam int QUO_WIDTH   = COORD_WIDTH - 1;
    // Input register, saturation stage, quotient stages, two merge stages.
    localparam int PIPE_DEPTH  = COORD_WIDTH + 3;

    localparam logic [COORD_WIDTH-1:0] T_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t dir_x;
        coord_t dir_y;
        coord_t dir_z;
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_min_z;
        coord_t box_max_x;
        coord_t box_max_y;
        coord_t box_max_z;
    } ray_item_t;

    typedef struct packed {
        logic hit;
    } hit_item_t;

    // Unsigned quotient of one lane with its saturation and sign marks.
    typedef struct packed {
        logic [QUO_WIDTH-1:0] quo;
        logic                 sat;
        logic                 neg;
    } lane_res_t;

endpackage

// ===== sv/rbs_if.sv =====
// Valid/ready stream interfaces for the ray/box slab test.
// Depends on rbs_pkg for the payload types.
interface rbs_ray_if import rbs_pkg::*;;
    logic      valid;
    logic      ready;
    ray_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbs_hit_if import rbs_pkg::*;;
    logic      valid;
    logic      ready;
    hit_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/rbs_div_lane.sv =====
// Restoring divider lane: saturation stage, then one quotient bit per stage.
// Depends on rbs_pkg for widths and the lane result type.
module rbs_div_lane import rbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [DIFF_WIDTH-1:0] num_mag,
    input  logic [COORD_WIDTH-1:0] den_mag,
    input  logic                  neg,
    output lane_res_t             res
);

    logic [NUM_WIDTH-1:0]   rem_reg [1:COORD_WIDTH];
    logic [QUO_WIDTH-1:0]   quo_reg [1:COORD_WIDTH];
    logic [COORD_WIDTH-1:0] den_reg [1:COORD_WIDTH];
    logic                   sat_reg [1:COORD_WIDTH];
    logic                   neg_reg [1:COORD_WIDTH];

    for (genvar s = 0; s < COORD_WIDTH; s++)
    begin : g_stage
        localparam int J = COORD_WIDTH - 1 - s;
        logic trial;

        if (s == 0)
        begin : g_sat
            logic [NUM_WIDTH-1:0] rem_in;

            // Stage zero input: numerator scaled by the fraction bits.
            assign rem_in = {num_mag, {FRAC_BITS{1'b0}}};
            assign trial  = (rem_in >> J) >= NUM_WIDTH'(den_mag);

            // Top quotient bit set means the magnitude exceeds the limit.
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s+1] <= rem_in;
                    quo_reg[s+1] <= '0;
                    den_reg[s+1] <= den_mag;
                    sat_reg[s+1] <= trial;
                    neg_reg[s+1] <= neg;
                end
            end
        end
        else
        begin : g_bit
            assign trial = (rem_reg[s] >> J) >= NUM_WIDTH'(den_reg[s]);

            // Restoring step for quotient bit J.
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s+1] <= trial ? rem_reg[s] - (NUM_WIDTH'(den_reg[s]) << J)
                                          : rem_reg[s];
                    quo_reg[s+1] <= quo_reg[s] | (QUO_WIDTH'(trial) << J);
                    den_reg[s+1] <= den_reg[s];
                    sat_reg[s+1] <= sat_reg[s];
                    neg_reg[s+1] <= neg_reg[s];
                end
            end
        end
    end

    assign res.quo = quo_reg[COORD_WIDTH];
    assign res.sat = sat_reg[COORD_WIDTH];
    assign res.neg = neg_reg[COORD_WIDTH];

endmodule

// ===== sv/rbs_merge.sv =====
// Merge stage: signs the lane quotients, orders each slab, reduces to a hit.
// Depends on rbs_pkg for widths, limits and the lane result type.
module rbs_merge import rbs_pkg::*;
(
    input  logic                           clk,
    input  logic                           en,
    input  lane_res_t [NUM_LANES-1:0]      lanes,
    input  logic [NUM_AXES-1:0]            par,
    input  logic                           ok,
    output logic                           hit
);

    coord_t near_reg [NUM_AXES];
    coord_t far_reg  [NUM_AXES];
    logic   ok_reg;
    logic   hit_reg;
    coord_t t_val    [NUM_LANES];
    coord_t entry_v;
    coord_t exit_v;

    // Saturate and apply the sign of each quotient.
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            logic [COORD_WIDTH-1:0] m;
            m = lanes[l].sat ? T_MAX : {1'b0, lanes[l].quo};
            t_val[l] = lanes[l].neg ? -coord_t'(m) : coord_t'(m);
        end
    end

    // Order each slab; a parallel axis adds no bound.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (par[a])
                begin
                    near_reg[a] <= -coord_t'(T_MAX);
                    far_reg[a]  <= coord_t'(T_MAX);
                end
                else if (t_val[2*a] < t_val[2*a+1])
                begin
                    near_reg[a] <= t_val[2*a];
                    far_reg[a]  <= t_val[2*a+1];
                end
                else
                begin
                    near_reg[a] <= t_val[2*a+1];
                    far_reg[a]  <= t_val[2*a];
                end
            end
            ok_reg <= ok;
        end
    end

    // Entry is the largest near value, exit the smallest far value.
    always_comb
    begin
        entry_v = near_reg[0];
        exit_v  = far_reg[0];
        for (int a = 1; a < NUM_AXES; a++)
        begin
            if (near_reg[a] > entry_v)
                entry_v = near_reg[a];
            if (far_reg[a] < exit_v)
                exit_v = far_reg[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            hit_reg <= ok_reg && (entry_v <= exit_v) && (exit_v >= 0);
    end

    assign hit = hit_reg;

endmodule

// ===== sv/ray_box_slab_test.sv =====
// Top level of the ray/box slab test: input stage, six divider lanes, merge.
// Depends on rbs_pkg, rbs_if, rbs_div_lane and rbs_merge.
//
// Usage: each beat on the ray channel carries one ray (origin, direction)
// and one box (lower and upper corner) in signed Q16.16. Each beat yields
// exactly one beat on the res channel with the hit flag, in order.
// Six divider lanes, two per axis, form the slab distances side by side;
// each lane is a restoring divider with a saturation stage and then one
// quotient bit per stage. The pipeline has one input register, COORD_WIDTH
// divider stages and two merge stages.
// Throughput is one beat per cycle unless the receiver stalls, set by the fully pipelined lanes.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and ray.ready drops until the waiting beat is taken.
// Reset clears the valid marks of all stages; no result is in flight after.
module ray_box_slab_test import rbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rbs_ray_if.sink    ray,
    rbs_hit_if.source  res
);

    logic                   vld_reg [0:PIPE_DEPTH-1];
    logic                   adv;
    coord_t                 o_v   [NUM_AXES];
    coord_t                 d_v   [NUM_AXES];
    coord_t                 lo_v  [NUM_AXES];
    coord_t                 hi_v  [NUM_AXES];
    logic [DIFF_WIDTH-1:0]  nlo_reg [NUM_AXES];
    logic [DIFF_WIDTH-1:0]  nhi_reg [NUM_AXES];
    logic [COORD_WIDTH-1:0] dm_reg  [NUM_AXES];
    logic                   neglo_reg [NUM_AXES];
    logic                   neghi_reg [NUM_AXES];
    logic [NUM_AXES-1:0]    par_reg;
    logic                   ok_reg;
    logic [NUM_AXES-1:0]    spar_reg [0:COORD_WIDTH-1];
    logic                   sok_reg  [0:COORD_WIDTH-1];
    lane_res_t [NUM_LANES-1:0] lanes;
    logic                   hit;

    // The pipeline moves unless a finished beat is waiting.
    assign adv       = !vld_reg[PIPE_DEPTH-1] || res.ready;
    assign ray.ready = adv;
    assign res.valid = vld_reg[PIPE_DEPTH-1];
    assign res.data.hit = hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= ray.valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    assign o_v  = '{ray.data.origin_x, ray.data.origin_y, ray.data.origin_z};
    assign d_v  = '{ray.data.dir_x, ray.data.dir_y, ray.data.dir_z};
    assign lo_v = '{ray.data.box_min_x, ray.data.box_min_y, ray.data.box_min_z};
    assign hi_v = '{ray.data.box_max_x, ray.data.box_max_y, ray.data.box_max_z};

    // Input stage: slab differences, magnitudes, signs and parallel checks.
    always_ff @(posedge clk)
    begin
        logic signed [DIFF_WIDTH-1:0] dlo;
        logic signed [DIFF_WIDTH-1:0] dhi;
        logic                         in_slab;
        logic                         ok_v;
        if (adv)
        begin
            ok_v = 1'b1;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                dlo = DIFF_WIDTH'(lo_v[a]) - DIFF_WIDTH'(o_v[a]);
                dhi = DIFF_WIDTH'(hi_v[a]) - DIFF_WIDTH'(o_v[a]);
                nlo_reg[a]   <= dlo[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dlo) : DIFF_WIDTH'(dlo);
                nhi_reg[a]   <= dhi[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dhi) : DIFF_WIDTH'(dhi);
                neglo_reg[a] <= dlo[DIFF_WIDTH-1] ^ d_v[a][COORD_WIDTH-1];
                neghi_reg[a] <= dhi[DIFF_WIDTH-1] ^ d_v[a][COORD_WIDTH-1];
                dm_reg[a]    <= d_v[a][COORD_WIDTH-1] ? COORD_WIDTH'(-d_v[a])
                                                      : COORD_WIDTH'(d_v[a]);
                par_reg[a]   <= (d_v[a] == 0);
                in_slab = (o_v[a] >= lo_v[a] && o_v[a] <= hi_v[a]) ||
                          (o_v[a] >= hi_v[a] && o_v[a] <= lo_v[a]);
                if (d_v[a] == 0 && !in_slab)
                    ok_v = 1'b0;
            end
            ok_reg <= ok_v;
        end
    end

    // Side information travels beside the divider lanes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            spar_reg[0] <= par_reg;
            sok_reg[0]  <= ok_reg;
            for (int i = 1; i < COORD_WIDTH; i++)
            begin
                spar_reg[i] <= spar_reg[i-1];
                sok_reg[i]  <= sok_reg[i-1];
            end
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        rbs_div_lane u_lane_lo
        (
            .clk     (clk),
            .en      (adv),
            .num_mag (nlo_reg[a]),
            .den_mag (dm_reg[a]),
            .neg     (neglo_reg[a]),
            .res     (lanes[2*a])
        );
        rbs_div_lane u_lane_hi
        (
            .clk     (clk),
            .en      (adv),
            .num_mag (nhi_reg[a]),
            .den_mag (dm_reg[a]),
            .neg     (neghi_reg[a]),
            .res     (lanes[2*a+1])
        );
    end

    rbs_merge u_merge
    (
        .clk   (clk),
        .en    (adv),
        .lanes (lanes),
        .par   (spar_reg[COORD_WIDTH-1]),
        .ok    (sok_reg[COORD_WIDTH-1]),
        .hit   (hit)
    );

    // A waiting result keeps its value until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.data.hit))
        else $error("result changed while stalled");

    // The input side is stalled exactly when a result waits.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ray.ready == (!res.valid || res.ready))
        else $error("input ready does not follow the output stall");

    // An accepted beat enters the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        ray.valid && ray.ready |=> vld_reg[0])
        else $error("accepted beat lost at the input stage");

endmodule
